@@ design/rvep_pkg.sv @@
// Shared widths and types for the raster valid-extent points core.
`default_nettype none

package rvep_pkg;

   localparam int CoordBits  = 16;
   localparam int SampleBits = 16;

   typedef logic [CoordBits-1:0]  coord_type;
   typedef logic [SampleBits-1:0] sample_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
   } point_type;

   typedef struct packed {
      point_type top;
      point_type right;
      point_type bottom;
      point_type left;
   } extent_type;

endpackage

`default_nettype wire

@@ design/raster_valid_extent_points_core.sv @@
// Streaming tracker of the four extreme valid points of a raster.
//
//   port group | direction | beat content
//   req_       | in        | sample_value, column, row, last_sample
//   rsp_       | out       | any_valid and four extreme points (col, row)
//   csr_       | in        | null_sample write, no read-back
//
// One beat per cycle while req_stall is low: an input register feeds the point compares, whose
// result goes to the running extent and, on a last beat, to the output register.
// rsp_valid rises once a last beat has passed the input register and been loaded into the output register.
// Reset clears the pipeline, the running extent and null_sample.
// req_stall rises only while a last beat waits on a full, stalled output register.
`default_nettype none

module raster_valid_extent_points_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire rvep_pkg::sample_type req_sample_value,
   input  wire rvep_pkg::coord_type  req_column,
   input  wire rvep_pkg::coord_type  req_row,
   input  wire                   req_last_sample,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_any_valid,
   output rvep_pkg::coord_type   rsp_top_column,
   output rvep_pkg::coord_type   rsp_top_row,
   output rvep_pkg::coord_type   rsp_right_column,
   output rvep_pkg::coord_type   rsp_right_row,
   output rvep_pkg::coord_type   rsp_bottom_column,
   output rvep_pkg::coord_type   rsp_bottom_row,
   output rvep_pkg::coord_type   rsp_left_column,
   output rvep_pkg::coord_type   rsp_left_row,
   input  wire                   csr_wr_en,
   input  wire rvep_pkg::sample_type csr_wr_data
);

   rvep_pkg::sample_type null_ff;

   logic                 in_valid_ff;
   rvep_pkg::sample_type in_sample_ff;
   rvep_pkg::point_type  in_point_ff;
   logic                 in_last_ff;

   logic                 seen_ff, seen_in;
   rvep_pkg::extent_type ext_ff, ext_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_any_ff;
   rvep_pkg::extent_type out_ext_ff;

   logic                 advance;
   logic                 take;
   logic                 new_seen;
   rvep_pkg::extent_type new_ext;
   rvep_pkg::point_type  p;

   assign req_stall = in_valid_ff && in_last_ff && out_valid_ff && rsp_stall;
   assign advance   = in_valid_ff && !req_stall;
   assign take      = in_sample_ff != null_ff;
   assign p         = in_point_ff;

   always_comb begin
      new_seen = seen_ff;
      new_ext  = ext_ff;
      if (take) begin
         new_seen = 1'b1;
         if (!seen_ff) begin
            new_ext.top    = p;
            new_ext.right  = p;
            new_ext.bottom = p;
            new_ext.left   = p;
         end else begin
            if (p.row < ext_ff.top.row ||
                (p.row == ext_ff.top.row && p.col < ext_ff.top.col)) begin
               new_ext.top = p;
            end
            if (p.row > ext_ff.bottom.row ||
                (p.row == ext_ff.bottom.row && p.col < ext_ff.bottom.col)) begin
               new_ext.bottom = p;
            end
            if (p.col > ext_ff.right.col ||
                (p.col == ext_ff.right.col && p.row < ext_ff.right.row)) begin
               new_ext.right = p;
            end
            if (p.col < ext_ff.left.col ||
                (p.col == ext_ff.left.col && p.row > ext_ff.left.row)) begin
               new_ext.left = p;
            end
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      ext_in  = ext_ff;
      if (advance) begin
         if (in_last_ff) begin
            seen_in = 1'b0;
            ext_in  = '0;
         end else begin
            seen_in = new_seen;
            ext_in  = new_ext;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         null_ff      <= '0;
         in_valid_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         ext_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            null_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         seen_ff      <= seen_in;
         ext_ff       <= ext_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_sample_ff    <= req_sample_value;
         in_point_ff.col <= req_column;
         in_point_ff.row <= req_row;
         in_last_ff      <= req_last_sample;
      end
      if (advance && in_last_ff) begin
         out_any_ff <= new_seen;
         out_ext_ff <= new_ext;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_any_valid     = out_any_ff;
   assign rsp_top_column    = out_ext_ff.top.col;
   assign rsp_top_row       = out_ext_ff.top.row;
   assign rsp_right_column  = out_ext_ff.right.col;
   assign rsp_right_row     = out_ext_ff.right.row;
   assign rsp_bottom_column = out_ext_ff.bottom.col;
   assign rsp_bottom_row    = out_ext_ff.bottom.row;
   assign rsp_left_column   = out_ext_ff.left.col;
   assign rsp_left_row      = out_ext_ff.left.row;

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_any_ff |-> out_ext_ff == '0)
      else $error("empty raster result carries nonzero points");

   a_extent_order: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_any_ff |->
         out_ext_ff.top.row <= out_ext_ff.bottom.row &&
         out_ext_ff.left.col <= out_ext_ff.right.col)
      else $error("result extent out of order");

   a_unseen_is_zero: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> ext_ff == '0)
      else $error("running extent not clear while nothing seen");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> !seen_ff && out_valid_ff)
      else $error("last beat did not clear state and post result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && out_valid_ff)
      else $error("input stalled without a pending last beat");

endmodule

`default_nettype wire

@@ tb/raster_valid_extent_points_core_tb.sv @@
// Self-checking testbench for the raster valid-extent points core.
`timescale 1ns / 1ps

module raster_valid_extent_points_core_tb;

   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 4;

   typedef struct {
      rvep_pkg::sample_type value;
      rvep_pkg::coord_type  column;
      rvep_pkg::coord_type  row;
      bit                   last;
   } raster_sample_type;

   typedef struct packed {
      logic                 found;
      rvep_pkg::extent_type extent;
   } extent_report_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   rvep_pkg::sample_type req_sample_value = '0;
   rvep_pkg::coord_type  req_column = '0;
   rvep_pkg::coord_type  req_row = '0;
   logic                 req_last_sample = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_any_valid;
   rvep_pkg::coord_type  rsp_top_column, rsp_top_row, rsp_right_column, rsp_right_row;
   rvep_pkg::coord_type  rsp_bottom_column, rsp_bottom_row, rsp_left_column, rsp_left_row;
   logic                 csr_wr_en = 1'b0;
   rvep_pkg::sample_type csr_wr_data = '0;

   raster_sample_type pending_samples[$];
   extent_report_type reports_due[$];
   raster_sample_type bus_sample;

   // running extent of the raster in progress, as the core should hold it
   rvep_pkg::sample_type null_code = '0;
   bit                   extent_seen = 1'b0;
   rvep_pkg::extent_type running = '0;

   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   raster_valid_extent_points_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_any_valid    (rsp_any_valid),
      .rsp_top_column   (rsp_top_column),
      .rsp_top_row      (rsp_top_row),
      .rsp_right_column (rsp_right_column),
      .rsp_right_row    (rsp_right_row),
      .rsp_bottom_column(rsp_bottom_column),
      .rsp_bottom_row   (rsp_bottom_row),
      .rsp_left_column  (rsp_left_column),
      .rsp_left_row     (rsp_left_row),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned draw_wait(bit enabled);
      return enabled ? $urandom_range(0, 11) : 0;
   endfunction

   task automatic absorb_sample(raster_sample_type s);
      rvep_pkg::point_type pt;
      extent_report_type report;
      pt.col = s.column;
      pt.row = s.row;
      if (s.value != null_code) begin
         if (!extent_seen) begin
            extent_seen = 1'b1;
            running.top = pt;
            running.right = pt;
            running.bottom = pt;
            running.left = pt;
         end else begin
            if (pt.row < running.top.row ||
                (pt.row == running.top.row && pt.col < running.top.col))
               running.top = pt;
            if (pt.row > running.bottom.row ||
                (pt.row == running.bottom.row && pt.col < running.bottom.col))
               running.bottom = pt;
            if (pt.col > running.right.col ||
                (pt.col == running.right.col && pt.row < running.right.row))
               running.right = pt;
            if (pt.col < running.left.col ||
                (pt.col == running.left.col && pt.row > running.left.row))
               running.left = pt;
         end
      end
      if (s.last) begin
         report.found = extent_seen;
         report.extent = running;
         reports_due.insert(reports_due.size(), report);
         extent_seen = 1'b0;
         running = '0;
      end
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         if (failures < 10)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_report;
      extent_report_type want;
      if (reports_due.size() == 0) begin
         if (failures < 10)
            $display("result beat with nothing expected at cycle %0d", cycle_count);
         failures++;
      end else begin
         want = reports_due.pop_front();
         check_field("any_valid", 16'(want.found), 16'(rsp_any_valid));
         check_field("top_column", want.extent.top.col, rsp_top_column);
         check_field("top_row", want.extent.top.row, rsp_top_row);
         check_field("right_column", want.extent.right.col, rsp_right_column);
         check_field("right_row", want.extent.right.row, rsp_right_row);
         check_field("bottom_column", want.extent.bottom.col, rsp_bottom_column);
         check_field("bottom_row", want.extent.bottom.row, rsp_bottom_row);
         check_field("left_column", want.extent.left.col, rsp_left_column);
         check_field("left_row", want.extent.left.row, rsp_left_row);
      end
   endtask

   // driver: hold a stalled beat, then idle for the drawn gap before the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            absorb_sample(bus_sample);
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            bus_sample = pending_samples.pop_front();
            req_sample_value <= bus_sample.value;
            req_column <= bus_sample.column;
            req_row <= bus_sample.row;
            req_last_sample <= bus_sample.last;
            req_valid <= 1'b1;
            gap_left = draw_wait(send_idle);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each result beat, then stall for the drawn count; stalls also start at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_report();
            stall_left = draw_wait(recv_idle);
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
         end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("raster_valid_extent_points_core regression: fail");
         $finish;
      end
   end

   function automatic void add_sample(rvep_pkg::sample_type value,
                                      rvep_pkg::coord_type column,
                                      rvep_pkg::coord_type row, bit last);
      raster_sample_type s;
      s.value = value;
      s.column = column;
      s.row = row;
      s.last = last;
      pending_samples.insert(pending_samples.size(), s);
   endfunction

   task automatic drain;
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_null(rvep_pkg::sample_type value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      null_code = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one well-formed raster: coordinates mostly clustered for ties, values mixed null and valid or all null
   function automatic int unsigned add_raster();
      int unsigned          count;
      int unsigned          span;
      bit                   all_null;
      rvep_pkg::coord_type  base_col;
      rvep_pkg::coord_type  base_row;
      rvep_pkg::sample_type value;
      rvep_pkg::coord_type  col;
      rvep_pkg::coord_type  row;
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      all_null = ($urandom_range(0, 9) == 0);
      base_col = rvep_pkg::coord_type'($urandom);
      base_row = rvep_pkg::coord_type'($urandom);
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value = null_code;
            4: value = null_code ^ (16'h1 << $urandom_range(0, 15));
            default: value = rvep_pkg::sample_type'($urandom);
         endcase
         if (all_null)
            value = null_code;
         col = (span == 0) ? rvep_pkg::coord_type'($urandom) :
               rvep_pkg::coord_type'(base_col + $urandom_range(0, span));
         row = (span == 0) ? rvep_pkg::coord_type'($urandom) :
               rvep_pkg::coord_type'(base_row + $urandom_range(0, span));
         add_sample(value, col, row, i == count - 1);
      end
      return count;
   endfunction

   initial begin
      rvep_pkg::sample_type phase_null[6];
      int unsigned          added;

      phase_null[0] = 16'h0000;
      phase_null[1] = rvep_pkg::sample_type'($urandom);
      phase_null[2] = 16'hFFFF;
      phase_null[3] = 16'h0001;
      phase_null[4] = 16'h8000;
      phase_null[5] = rvep_pkg::sample_type'($urandom);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // null value from reset: an empty raster, a single full-scale sample,
      // then ties, extra bands, repeated positions
      add_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
      add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      add_sample(16'h0001, 16'd5, 16'd5, 1'b0);
      add_sample(16'h0000, 16'd0, 16'd0, 1'b0);
      add_sample(16'h0007, 16'd3, 16'd5, 1'b0);
      add_sample(16'h0002, 16'd5, 16'd2, 1'b0);
      add_sample(16'h0002, 16'd9, 16'd2, 1'b0);
      add_sample(16'h0003, 16'd9, 16'd7, 1'b0);
      add_sample(16'h0000, 16'd9, 16'd7, 1'b0);
      add_sample(16'h0004, 16'd0, 16'd7, 1'b0);
      add_sample(16'h0004, 16'd0, 16'd1, 1'b0);
      add_sample(16'h0005, 16'd3, 16'd5, 1'b0);
      add_sample(16'h8000, 16'd4, 16'd9, 1'b0);
      add_sample(16'h0001, 16'd4, 16'd9, 1'b1);
      drain();

      write_null(16'hFFFF);
      add_sample(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      add_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      add_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
      add_sample(16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_sample(16'hFFFF, 16'd10, 16'd10, 1'b1);
      add_sample(16'hFFFF, 16'd1, 16'd1, 1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         send_idle = p[0];
         recv_idle = p[1];
         write_null(phase_null[p]);
         added = 0;
         while (added < 300)
            added += add_raster();
         drain();
      end

      repeat (8) @(posedge clock);
      if (failures == 0 && reports_due.size() == 0)
         $display("raster_valid_extent_points_core regression: pass");
      else
         $display("raster_valid_extent_points_core regression: fail");
      $finish;
   end

endmodule
